[rtl/core/h264_access_unit_splitter_macros.svh]
// Assertion macros for the access unit splitter checker.
`ifndef H264_ACCESS_UNIT_SPLITTER_MACROS_SVH
`define H264_ACCESS_UNIT_SPLITTER_MACROS_SVH

// Checked only while out of reset.
`define AUS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define AUS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/core/h264aus_pkg.sv]
// Shared types and constants for the H.264 access unit splitter.
package h264aus_pkg;

    localparam int OFFSET_BITS    = 32;
    localparam int CMP_BITS       = OFFSET_BITS + 32;
    localparam int Q_DEPTH        = 4;
    localparam int Q_PTR_BITS     = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS     = Q_PTR_BITS + 1;

    localparam logic [4:0]  NAL_TYPE_MASK  = 5'h1F;
    localparam logic [4:0]  MAX_SLICE_TYPE = 5'd5;
    localparam logic [7:0]  MISSING_BYTE   = 8'hFF;
    localparam logic [31:0] MAX_UNIT_RESET = 32'(3 * 1024 * 1024);

    typedef logic [OFFSET_BITS-1:0] t_offset;

    typedef enum logic [1:0] {
        PH_SCAN   = 2'd0,
        PH_HEADER = 2'd1,
        PH_FOLLOW = 2'd2
    } t_phase;

    typedef struct packed {
        logic [31:0] unit_start;
        logic [31:0] unit_length;
        logic [4:0]  first_nal_type;
        logic        oversize;
        logic        run_end;
    } t_result;

endpackage

[rtl/core/h264_access_unit_splitter.sv]
// H.264 Annex B access unit splitter: one byte per beat in, one unit per beat out.
// Pipeline: an accepted byte is first registered, then parsed from that register, and its
//   results are written into the result queue, which offers them on the output port.
// Throughput: one byte per cycle while the input is not stalled; a byte may close two units,
//   and input stalls while the four-entry result queue holds three or more.
// Reset: synchronous, active low; clears stream state and queue, max_unit_bytes = 3145728.
module h264_access_unit_splitter
    import h264aus_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_stream,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_unit_start,
    output logic [31:0] o_unit_length,
    output logic [4:0]  o_first_nal_type,
    output logic        o_oversize,
    output logic        o_run_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_eos;

    t_offset               r_pos;
    logic [1:0]            r_zero_run;
    t_phase                r_phase;
    t_offset               r_pcs;
    logic [4:0]            r_pnt;
    logic                  r_open;
    logic                  r_single;
    t_offset               r_ubegin;
    logic [4:0]            r_utype;
    logic [31:0]           r_max;

    t_result               r_q [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr;
    logic [Q_PTR_BITS-1:0] r_rd_ptr;
    logic [Q_CNT_BITS-1:0] r_count;

    t_offset               n_pos;
    logic [1:0]            n_zero_run;
    t_phase                n_phase;
    t_offset               n_pcs;
    logic [4:0]            n_pnt;
    logic                  n_open;
    logic                  n_single;
    t_offset               n_ubegin;
    logic [4:0]            n_utype;

    logic [1:0]            em_cnt;
    t_offset               em_begin [2];
    t_offset               em_end   [2];
    logic [4:0]            em_type  [2];
    t_result               res      [2];

    logic                  go;
    logic                  pop;

    assign go          = r_in_valid && (r_count <= Q_CNT_BITS'(Q_DEPTH - 2));
    assign o_in_stall  = r_in_valid && !go;
    assign o_out_valid = (r_count != '0);
    assign pop         = o_out_valid && !i_out_stall;
    assign o_cfg_ready = 1'b1;

    assign o_unit_start     = r_q[r_rd_ptr].unit_start;
    assign o_unit_length    = r_q[r_rd_ptr].unit_length;
    assign o_first_nal_type = r_q[r_rd_ptr].first_nal_type;
    assign o_oversize       = r_q[r_rd_ptr].oversize;
    assign o_run_end        = r_q[r_rd_ptr].run_end;

    // Per-byte parse; emits at most two units.
    always_comb begin
        logic [4:0] htype;
        t_offset    len;

        n_pos      = r_pos;
        n_zero_run = r_zero_run;
        n_phase    = r_phase;
        n_pcs      = r_pcs;
        n_pnt      = r_pnt;
        n_open     = r_open;
        n_single   = r_single;
        n_ubegin   = r_ubegin;
        n_utype    = r_utype;
        em_cnt     = '0;
        htype      = '0;
        len        = '0;
        for (int k = 0; k < 2; k++) begin
            em_begin[k] = '0;
            em_end[k]   = '0;
            em_type[k]  = '0;
        end

        unique case (r_phase)
            PH_HEADER: begin
                htype   = r_in_byte[4:0] & NAL_TYPE_MASK;
                n_pnt   = htype;
                n_phase = PH_SCAN;
                if (!n_open) begin
                    n_open   = 1'b1;
                    n_ubegin = n_pcs;
                    n_utype  = htype;
                    n_single = (htype > MAX_SLICE_TYPE);
                end else if (n_single) begin
                    em_begin[0] = n_ubegin;
                    em_end[0]   = n_pcs;
                    em_type[0]  = n_utype;
                    em_cnt      = 2'd1;
                    n_ubegin    = n_pcs;
                    n_utype     = htype;
                    n_single    = (htype > MAX_SLICE_TYPE);
                end else if (htype <= MAX_SLICE_TYPE) begin
                    n_phase = PH_FOLLOW;
                end
            end
            PH_FOLLOW: begin
                n_phase = PH_SCAN;
                if (r_in_byte[7]) begin
                    em_begin[0] = n_ubegin;
                    em_end[0]   = n_pcs;
                    em_type[0]  = n_utype;
                    em_cnt      = 2'd1;
                    n_open      = 1'b1;
                    n_ubegin    = n_pcs;
                    n_utype     = n_pnt;
                    n_single    = (n_pnt > MAX_SLICE_TYPE);
                end
            end
            default: n_phase = PH_SCAN;
        endcase

        if (r_in_byte == 8'd0) begin
            if (n_zero_run != 2'd3) begin
                n_zero_run = n_zero_run + 2'd1;
            end
        end else if (r_in_byte == 8'd1 && n_zero_run >= 2'd2) begin
            n_pcs      = r_pos - t_offset'(n_zero_run);
            n_phase    = PH_HEADER;
            n_zero_run = '0;
        end else begin
            n_zero_run = '0;
        end
        n_pos = r_pos + t_offset'(1);

        if (r_in_eos) begin
            // Missing header byte reads as all ones: non-slice type.
            if (n_phase == PH_HEADER) begin
                htype   = MISSING_BYTE[4:0] & NAL_TYPE_MASK;
                n_pnt   = htype;
                n_phase = PH_SCAN;
                if (!n_open) begin
                    n_open   = 1'b1;
                    n_ubegin = n_pcs;
                    n_utype  = htype;
                    n_single = (htype > MAX_SLICE_TYPE);
                end else if (n_single) begin
                    em_begin[em_cnt[0]] = n_ubegin;
                    em_end[em_cnt[0]]   = n_pcs;
                    em_type[em_cnt[0]]  = n_utype;
                    em_cnt              = em_cnt + 2'd1;
                    n_ubegin            = n_pcs;
                    n_utype             = htype;
                    n_single            = (htype > MAX_SLICE_TYPE);
                end else if (htype <= MAX_SLICE_TYPE) begin
                    n_phase = PH_FOLLOW;
                end
            end
            if (n_phase == PH_FOLLOW) begin
                n_phase             = PH_SCAN;
                em_begin[em_cnt[0]] = n_ubegin;
                em_end[em_cnt[0]]   = n_pcs;
                em_type[em_cnt[0]]  = n_utype;
                em_cnt              = em_cnt + 2'd1;
                n_open              = 1'b1;
                n_ubegin            = n_pcs;
                n_utype             = n_pnt;
                n_single            = (n_pnt > MAX_SLICE_TYPE);
            end
            if (n_open) begin
                em_begin[em_cnt[0]] = n_ubegin;
                em_end[em_cnt[0]]   = n_pos;
                em_type[em_cnt[0]]  = n_utype;
                em_cnt              = em_cnt + 2'd1;
            end
            n_pos      = '0;
            n_zero_run = '0;
            n_phase    = PH_SCAN;
            n_pcs      = '0;
            n_pnt      = '0;
            n_open     = 1'b0;
            n_single   = 1'b0;
            n_ubegin   = '0;
            n_utype    = '0;
        end

        for (int k = 0; k < 2; k++) begin
            len                   = em_end[k] - em_begin[k];
            res[k].unit_start     = 32'(em_begin[k]);
            res[k].unit_length    = 32'(len);
            res[k].first_nal_type = em_type[k];
            res[k].oversize       = (CMP_BITS'(len) > CMP_BITS'(r_max));
            res[k].run_end        = (em_cnt == 2'(k + 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_eos  <= i_end_of_stream;
        end
        if (go) begin
            if (em_cnt != 2'd0) begin
                r_q[r_wr_ptr] <= res[0];
            end
            if (em_cnt == 2'd2) begin
                r_q[r_wr_ptr + Q_PTR_BITS'(1)] <= res[1];
            end
        end

        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pos      <= '0;
            r_zero_run <= '0;
            r_phase    <= PH_SCAN;
            r_pcs      <= '0;
            r_pnt      <= '0;
            r_open     <= 1'b0;
            r_single   <= 1'b0;
            r_ubegin   <= '0;
            r_utype    <= '0;
            r_max      <= MAX_UNIT_RESET;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_max <= i_cfg_data;
            end
            if (go) begin
                r_pos      <= n_pos;
                r_zero_run <= n_zero_run;
                r_phase    <= n_phase;
                r_pcs      <= n_pcs;
                r_pnt      <= n_pnt;
                r_open     <= n_open;
                r_single   <= n_single;
                r_ubegin   <= n_ubegin;
                r_utype    <= n_utype;
                r_wr_ptr   <= r_wr_ptr + Q_PTR_BITS'(em_cnt);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_BITS'(1);
            end
            r_count <= r_count + (go ? Q_CNT_BITS'(em_cnt) : '0)
                               - (pop ? Q_CNT_BITS'(1) : '0);
        end
    end

endmodule

[rtl/core/h264aus_checker.sv]
// Port-level checker for the access unit splitter, bound to the top level.
`include "h264_access_unit_splitter_macros.svh"

module h264aus_checker
    import h264aus_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_unit_start,
    input logic [31:0] o_unit_length,
    input logic [4:0]  o_first_nal_type,
    input logic        o_oversize,
    input logic        o_run_end
);

    t_result out_beat;
    logic    out_held;
    logic    first_taken;

    assign out_beat = '{o_unit_start, o_unit_length, o_first_nal_type, o_oversize, o_run_end};
    assign out_held    = o_out_valid && i_out_stall;
    assign first_taken = o_out_valid && !i_out_stall && !o_run_end;

    `AUS_ASSERT(a_out_hold, out_held |=> o_out_valid && $stable(out_beat), "result not held")
    `AUS_ASSERT(a_pair_follows, first_taken |=> o_out_valid, "second result missing")
    `AUS_ASSERT_RST(a_rst_out, !i_rst_n |=> !o_out_valid, "result valid after reset")
    `AUS_ASSERT_RST(a_rst_in, !i_rst_n |=> !o_in_stall, "input stalled after reset")

endmodule

bind h264_access_unit_splitter h264aus_checker u_h264aus_checker (.*);

[test/h264_access_unit_splitter_tb.sv]
// Testbench for the H.264 access unit splitter: random and directed byte streams, self-checked.
`timescale 1ns / 100ps

module h264_access_unit_splitter_tb;
    import h264aus_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_BYTES   = 300;

    typedef enum logic {BEAT_BYTE, BEAT_CFG} t_beat_kind;

    typedef struct {
        t_beat_kind  kind;
        logic [7:0]  data;
        logic        eos;
        logic [31:0] value;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        eos = 1'b0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [31:0] cfg_data = 32'h0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_unit_start;
    logic [31:0] o_unit_length;
    logic [4:0]  o_first_nal_type;
    logic        o_oversize;
    logic        o_run_end;
    logic        o_cfg_ready;

    t_beat       byte_queue[$];
    logic [7:0]  stream_buf[$];
    t_result     au_expected[$];
    t_result     step_res[$];
    int          n_err = 0;
    int          n_fill = 0;

    // splitter state as predicted
    logic [31:0] max_bytes = MAX_UNIT_RESET;
    logic [31:0] pos_cnt = '0;
    logic [1:0]  zrun = '0;
    t_phase      phase = PH_SCAN;
    logic [31:0] code_start = '0;
    logic [4:0]  nal_pend = '0;
    logic        au_on = 1'b0;
    logic        au_single = 1'b0;
    logic [31:0] au_begin = '0;
    logic [4:0]  au_type = '0;

    int          gap_left = 0;
    int          burst_left = 0;
    int          settle = 0;
    int          stall_mode = 0;
    int          stall_left = 0;

    h264_access_unit_splitter u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (data_byte),
        .i_end_of_stream  (eos),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_unit_start     (o_unit_start),
        .o_unit_length    (o_unit_length),
        .o_first_nal_type (o_first_nal_type),
        .o_oversize       (o_oversize),
        .o_run_end        (o_run_end),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        n_err++;
    endtask

    function automatic void au_close(input logic [31:0] end_pos);
        t_result r;
        if (step_res.size() >= 2) return;
        r.unit_start     = au_begin;
        r.unit_length    = end_pos - au_begin;
        r.first_nal_type = au_type;
        r.oversize       = (r.unit_length > max_bytes);
        r.run_end        = 1'b0;
        step_res.insert(step_res.size(), r);
    endfunction

    function automatic void au_start(input logic [4:0] ty);
        au_on     = 1'b1;
        au_begin  = code_start;
        au_type   = ty;
        au_single = (ty > MAX_SLICE_TYPE);
    endfunction

    function automatic void nal_header(input logic [7:0] b);
        logic [4:0] ty;
        ty       = b[4:0] & NAL_TYPE_MASK;
        nal_pend = ty;
        phase    = PH_SCAN;
        if (!au_on) begin
            au_start(ty);
        end else if (au_single) begin
            au_close(code_start);
            au_start(ty);
        end else if (ty <= MAX_SLICE_TYPE) begin
            phase = PH_FOLLOW;
        end
    endfunction

    function automatic void slice_follow(input logic [7:0] b);
        phase = PH_SCAN;
        if (b[7]) begin
            au_close(code_start);
            au_start(nal_pend);
        end
    endfunction

    function automatic void split_byte(input logic [7:0] b, input logic last);
        t_result r;
        step_res.delete();
        case (phase)
            PH_HEADER: nal_header(b);
            PH_FOLLOW: slice_follow(b);
            default:   phase = PH_SCAN;
        endcase
        if (b == 8'h00) begin
            if (zrun < 2'd3) zrun = zrun + 2'd1;
        end else if (b == 8'h01 && zrun >= 2'd2) begin
            code_start = pos_cnt - 32'(zrun);
            phase      = PH_HEADER;
            zrun       = '0;
        end else begin
            zrun = '0;
        end
        pos_cnt = pos_cnt + 32'd1;
        if (last) begin
            if (phase == PH_HEADER) nal_header(MISSING_BYTE);
            if (phase == PH_FOLLOW) slice_follow(MISSING_BYTE);
            if (au_on) au_close(pos_cnt);
            pos_cnt    = '0;
            zrun       = '0;
            phase      = PH_SCAN;
            code_start = '0;
            nal_pend   = '0;
            au_on      = 1'b0;
            au_single  = 1'b0;
            au_begin   = '0;
            au_type    = '0;
        end
        if (step_res.size() > 0) begin
            r = step_res.pop_back();
            r.run_end = 1'b1;
            step_res.insert(step_res.size(), r);
        end
        foreach (step_res[i]) au_expected.insert(au_expected.size(), step_res[i]);
    endfunction

    task automatic flush_stream();
        foreach (stream_buf[i]) begin
            byte_queue.insert(byte_queue.size(),
                              t_beat'{kind: BEAT_BYTE, data: stream_buf[i],
                                      eos: (i == stream_buf.size() - 1), value: 32'h0});
            n_fill++;
        end
        stream_buf.delete();
    endtask

    // mostly well-formed streams; some noise, some cut short at a header
    task automatic add_stream();
        int mode;
        int n_nal;
        int z;
        logic [7:0] hb;
        mode = $urandom_range(0, 19);
        if (mode == 0) begin
            repeat ($urandom_range(1, 24))
                stream_buf.insert(stream_buf.size(),
                                  ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 1))
                                                              : 8'($urandom));
        end else begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3))
                    stream_buf.insert(stream_buf.size(), 8'($urandom_range(1, 255)));
            n_nal = $urandom_range(1, 8);
            for (int k = 0; k < n_nal; k++) begin
                z = ($urandom_range(0, 9) < 7) ? 2 : $urandom_range(3, 6);
                repeat (z) stream_buf.insert(stream_buf.size(), 8'h00);
                stream_buf.insert(stream_buf.size(), 8'h01);
                if (mode == 1 && k == n_nal - 1) break;
                hb = 8'($urandom);
                if ($urandom_range(0, 2) != 0) hb[4:0] = 5'($urandom_range(1, 5));
                stream_buf.insert(stream_buf.size(), hb);
                if (mode == 2 && k == n_nal - 1) break;
                stream_buf.insert(stream_buf.size(), 8'($urandom));
                repeat ($urandom_range(0, 6))
                    stream_buf.insert(stream_buf.size(),
                                      ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom));
            end
        end
        flush_stream();
    endtask

    // driver
    always @(posedge i_clk) begin
        logic acc_in;
        logic acc_cfg;
        logic nxt_in;
        logic nxt_cfg;
        t_beat bt;
        if (!i_rst_n) begin
            in_valid   <= 1'b0;
            cfg_valid  <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
            settle     <= 0;
        end else begin
            acc_in  = in_valid && !o_in_stall;
            acc_cfg = cfg_valid && o_cfg_ready;
            if (acc_in) split_byte(data_byte, eos);
            if (acc_cfg) max_bytes = cfg_data;
            if ((in_valid && !acc_in) || (cfg_valid && !acc_cfg)) begin
                // hold the stalled beat
            end else begin
                nxt_in  = 1'b0;
                nxt_cfg = 1'b0;
                if (byte_queue.size() > 0) begin
                    if (byte_queue[0].kind == BEAT_CFG) begin
                        // drain all results before touching the register
                        if (acc_in || au_expected.size() != 0) begin
                            settle <= 0;
                        end else if (settle < SETTLE_CYCLES) begin
                            settle <= settle + 1;
                        end else begin
                            bt = byte_queue.pop_front();
                            cfg_data <= bt.value;
                            nxt_cfg  = 1'b1;
                            settle   <= 0;
                        end
                    end else if (gap_left > 0) begin
                        gap_left <= gap_left - 1;
                    end else begin
                        bt = byte_queue.pop_front();
                        data_byte <= bt.data;
                        eos       <= bt.eos;
                        nxt_in    = 1'b1;
                        if (burst_left == 0) begin
                            burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                                       : $urandom_range(1, 12);
                            gap_left   <= $urandom_range(0, 6);
                        end else begin
                            burst_left <= burst_left - 1;
                        end
                    end
                end
                in_valid  <= nxt_in;
                cfg_valid <= nxt_cfg;
            end
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(8, 120);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(0, 1));
            2:       out_stall <= ($urandom_range(0, 7) == 0);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // monitor
    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (au_expected.size() == 0) begin
                report($sformatf("unexpected unit start=0x%0h len=0x%0h",
                                 o_unit_start, o_unit_length));
            end else begin
                w = au_expected.pop_front();
                if (o_unit_start !== w.unit_start)
                    report($sformatf("unit_start got 0x%0h exp 0x%0h",
                                     o_unit_start, w.unit_start));
                if (o_unit_length !== w.unit_length)
                    report($sformatf("unit_length got 0x%0h exp 0x%0h",
                                     o_unit_length, w.unit_length));
                if (o_first_nal_type !== w.first_nal_type)
                    report($sformatf("first_nal_type got %0d exp %0d",
                                     o_first_nal_type, w.first_nal_type));
                if (o_oversize !== w.oversize)
                    report($sformatf("oversize got %0b exp %0b", o_oversize, w.oversize));
                if (o_run_end !== w.run_end)
                    report($sformatf("run_end got %0b exp %0b", o_run_end, w.run_end));
            end
        end
    end

    initial begin
        logic [31:0] cfg_set[6];
        int mark;
        cfg_set = '{32'd1, 32'hFFFF_FFFF, 32'd16, 32'($urandom_range(8, 48)),
                    MAX_UNIT_RESET, 32'd24};

        // slice, appended SEI, long zero run, slice with bit 7 clear, trailing SPS
        stream_buf = '{8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'h00, 8'h01, 8'h06,
                       8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h41, 8'h1A,
                       8'h00, 8'h00, 8'h01, 8'h67};
        flush_stream();
        // header cut by end of stream
        stream_buf = '{8'h00, 8'h00, 8'h01};
        flush_stream();
        // no start code at all
        stream_buf = '{8'hFF, 8'h34};
        flush_stream();

        foreach (cfg_set[p]) begin
            byte_queue.insert(byte_queue.size(),
                              t_beat'{kind: BEAT_CFG, data: 8'h00, eos: 1'b0,
                                      value: cfg_set[p]});
            mark = n_fill;
            while (n_fill - mark < PHASE_BYTES) add_stream();
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_queue.size() != 0 || in_valid || cfg_valid) @(posedge i_clk);
        while (au_expected.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_err == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
